/* rtl/roman_minute_pulse_pattern_defines.svh */
// Assertion macros used by the checker file of the minute pulse pattern block.
`ifndef ROMAN_MINUTE_PULSE_PATTERN_DEFINES_SVH
`define ROMAN_MINUTE_PULSE_PATTERN_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define RMPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmpp assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RMPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmpp assertion failed");

`endif

/* rtl/rmpp_pkg.sv */
// Shared types and constants of the minute pulse pattern block.
`timescale 1ns / 1ps
package rmpp_pkg;

	localparam int MINUTE_W = 7;
	localparam int CAP_W    = 6;
	localparam int DUR_W    = 16;
	localparam int IDX_W    = 5;

	localparam logic [MINUTE_W-1:0] HARD_MINUTE_LIMIT = 7'd99;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_MAX_MINUTE = 3'd0;
	localparam logic [2:0] REG_CAPACITY   = 3'd1;
	localparam logic [2:0] REG_SHORT_MS   = 3'd2;
	localparam logic [2:0] REG_MEDIUM_MS  = 3'd3;
	localparam logic [2:0] REG_LONG_MS    = 3'd4;
	localparam logic [2:0] REG_GAP_MS     = 3'd5;

	// Reset values
	localparam logic [MINUTE_W-1:0] RST_MAX_MINUTE = 7'd59;
	localparam logic [CAP_W-1:0]    RST_CAPACITY   = 6'd32;
	localparam logic [DUR_W-1:0]    RST_SHORT_MS   = 16'd125;
	localparam logic [DUR_W-1:0]    RST_MEDIUM_MS  = 16'd250;
	localparam logic [DUR_W-1:0]    RST_LONG_MS    = 16'd500;
	localparam logic [DUR_W-1:0]    RST_GAP_MS     = 16'd75;

	// Classified minute handed from front to back
	typedef struct packed {
		logic [3:0]       tens;
		logic [3:0]       ones;
		logic [IDX_W-1:0] last_idx;
	} desc_t;

	// Settings the back end reads while emitting
	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic [DUR_W-1:0] short_ms;
		logic [DUR_W-1:0] medium_ms;
		logic [DUR_W-1:0] long_ms;
		logic [DUR_W-1:0] gap_ms;
	} emit_cfg_t;

endpackage

/* rtl/roman_minute_pulse_pattern.sv */
// Top level of the Roman-numeral minute vibration pattern generator.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid/in_ready/minute): one transaction per minute value.
//    A minute of zero, or above min(max_minute, 99), is taken and yields nothing.
//  - Output channel (out_valid/out_ready + fields): one transaction per pattern
//    entry; pulses on even entry_index, gaps on odd, last set on the final one.
//    A pattern holds 2*pulses-1 entries, at most 25.
//  - The first entry is registered: the minute is written into the queue when
//    taken, then the back end loads its entries into the output register.
//  - Throughput: one entry per cycle while out_ready is high and a minute is
//    queued; an item has 1..25 entries, walked by the back-end entry counter.
//  - A two-deep queue of classified minutes lets the input accept while the
//    back end is still emitting; in_ready drops only when the queue is full.
//  - A stalled receiver holds the output register; the back end freezes with it.
//  - Reset empties the queue and output register and loads register defaults
//    (max_minute 59, capacity 32, short 125, medium 250, long 500, gap 75).
//  - APB registers at byte addresses 0x00..0x14; write only while idle.
module roman_minute_pulse_pattern #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// minute input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  minute,
	// pattern output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] duration_ms,
	output logic        is_pulse,
	output logic [4:0]  entry_index,
	output logic        stored,
	output logic        last
);
	import rmpp_pkg::*;

	logic [MINUTE_W-1:0] max_minute_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [DUR_W-1:0]    short_ms_q;
	logic [DUR_W-1:0]    medium_ms_q;
	logic [DUR_W-1:0]    long_ms_q;
	logic [DUR_W-1:0]    gap_ms_q;

	logic       cfg_wr;
	logic [2:0] reg_idx;

	logic      q_push;
	logic      q_push_ready;
	desc_t     q_push_data;
	logic      q_pop;
	logic      q_pop_valid;
	desc_t     q_pop_data;
	emit_cfg_t emit_cfg;

	// register file; pready is always high so access completes without wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_minute_q <= RST_MAX_MINUTE;
			capacity_q   <= RST_CAPACITY;
			short_ms_q   <= RST_SHORT_MS;
			medium_ms_q  <= RST_MEDIUM_MS;
			long_ms_q    <= RST_LONG_MS;
			gap_ms_q     <= RST_GAP_MS;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAX_MINUTE: max_minute_q <= pwdata[MINUTE_W-1:0];
				REG_CAPACITY:   capacity_q   <= pwdata[CAP_W-1:0];
				REG_SHORT_MS:   short_ms_q   <= pwdata[DUR_W-1:0];
				REG_MEDIUM_MS:  medium_ms_q  <= pwdata[DUR_W-1:0];
				REG_LONG_MS:    long_ms_q    <= pwdata[DUR_W-1:0];
				REG_GAP_MS:     gap_ms_q     <= pwdata[DUR_W-1:0];
				default: ; // unmapped: write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_MINUTE: prdata = 32'(max_minute_q);
			REG_CAPACITY:   prdata = 32'(capacity_q);
			REG_SHORT_MS:   prdata = 32'(short_ms_q);
			REG_MEDIUM_MS:  prdata = 32'(medium_ms_q);
			REG_LONG_MS:    prdata = 32'(long_ms_q);
			REG_GAP_MS:     prdata = 32'(gap_ms_q);
			default:        prdata = '0;
		endcase
	end

	assign emit_cfg.capacity  = capacity_q;
	assign emit_cfg.short_ms  = short_ms_q;
	assign emit_cfg.medium_ms = medium_ms_q;
	assign emit_cfg.long_ms   = long_ms_q;
	assign emit_cfg.gap_ms    = gap_ms_q;

	rmpp_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.minute     (minute),
		.max_minute (max_minute_q),
		.q_ready    (q_push_ready),
		.q_push     (q_push),
		.q_data     (q_push_data)
	);

	rmpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.push_ready (q_push_ready),
		.pop        (q_pop),
		.pop_valid  (q_pop_valid),
		.pop_data   (q_pop_data)
	);

	rmpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_pop_valid),
		.q_data      (q_pop_data),
		.q_pop       (q_pop),
		.cfg         (emit_cfg),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.duration_ms (duration_ms),
		.is_pulse    (is_pulse),
		.entry_index (entry_index),
		.stored      (stored),
		.last        (last)
	);

endmodule

/* rtl/rmpp_front.sv */
// Front end: accepts a minute, range-checks it and splits it into tens and ones.
`timescale 1ns / 1ps
module rmpp_front (
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rmpp_pkg::MINUTE_W-1:0]  minute,
	input  logic [rmpp_pkg::MINUTE_W-1:0]  max_minute,
	input  logic                           q_ready,
	output logic                           q_push,
	output rmpp_pkg::desc_t                q_data
);
	import rmpp_pkg::*;

	logic [MINUTE_W-1:0] limit;
	logic [14:0]         prod;
	logic [3:0]          tens;
	logic [MINUTE_W-1:0] ones_full;
	logic [3:0]          ones;
	logic [3:0]          ones_pulses;
	logic [3:0]          pulses;
	logic                keep;

	always_comb begin
		limit = (max_minute > HARD_MINUTE_LIMIT) ? HARD_MINUTE_LIMIT : max_minute;
		keep  = (minute != '0) && (minute <= limit);

		// divide by ten: x*205 >> 11 is exact over the 7-bit range
		prod      = 15'(minute) * 15'd205;
		tens      = prod[14:11];
		ones_full = minute - (MINUTE_W'(tens) * MINUTE_W'(10));
		ones      = ones_full[3:0];

		unique case (ones)
			4'd4, 4'd9:       ones_pulses = 4'd2;
			4'd5:             ones_pulses = 4'd1;
			4'd6, 4'd7, 4'd8: ones_pulses = ones - 4'd4;
			default:          ones_pulses = ones;
		endcase
		pulses = tens + ones_pulses;

		q_data.tens     = tens;
		q_data.ones     = ones;
		q_data.last_idx = {pulses, 1'b0} - IDX_W'(2);
	end

	assign in_ready = q_ready;
	assign q_push   = in_valid && q_ready && keep;

endmodule

/* rtl/rmpp_queue.sv */
// Small register FIFO between the front and back ends.
`timescale 1ns / 1ps
module rmpp_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rmpp_pkg::desc_t push_data,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output rmpp_pkg::desc_t pop_data
);
	import rmpp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/rmpp_back.sv */
// Back end: walks one classified minute and emits its entries into the output register.
`timescale 1ns / 1ps
module rmpp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rmpp_pkg::desc_t               q_data,
	output logic                          q_pop,
	input  rmpp_pkg::emit_cfg_t           cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rmpp_pkg::DUR_W-1:0]    duration_ms,
	output logic                          is_pulse,
	output logic [rmpp_pkg::IDX_W-1:0]    entry_index,
	output logic                          stored,
	output logic                          last
);
	import rmpp_pkg::*;

	typedef enum logic [1:0] {SYM_I, SYM_V, SYM_X} sym_t;

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [DUR_W-1:0] dur_q;
	logic             pulse_q;
	logic [IDX_W-1:0] index_q;
	logic             stored_q;
	logic             last_q;

	logic [3:0]       pulse_num;
	logic [3:0]       sym_pos;
	sym_t             sym;
	logic [DUR_W-1:0] dur_d;
	logic             at_end;
	logic             advance;

	always_comb begin
		pulse_num = idx_q[IDX_W-1:1];
		sym_pos   = pulse_num - q_data.tens;
		if (pulse_num < q_data.tens) begin
			sym = SYM_X;
		end else begin
			unique case (q_data.ones)
				4'd4:             sym = (sym_pos == '0) ? SYM_I : SYM_V;
				4'd9:             sym = (sym_pos == '0) ? SYM_I : SYM_X;
				4'd5, 4'd6, 4'd7,
				4'd8:             sym = (sym_pos == '0) ? SYM_V : SYM_I;
				default:          sym = SYM_I;
			endcase
		end
		if (idx_q[0]) begin
			dur_d = cfg.gap_ms;
		end else begin
			unique case (sym)
				SYM_X:   dur_d = cfg.long_ms;
				SYM_V:   dur_d = cfg.medium_ms;
				default: dur_d = cfg.short_ms;
			endcase
		end
	end

	assign at_end  = (idx_q == q_data.last_idx);
	assign advance = q_valid && (!out_valid_q || out_ready);
	assign q_pop   = advance && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? '0 : idx_q + IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dur_q    <= dur_d;
			pulse_q  <= !idx_q[0];
			index_q  <= idx_q;
			stored_q <= ({1'b0, idx_q} < cfg.capacity);
			last_q   <= at_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign duration_ms = dur_q;
	assign is_pulse    = pulse_q;
	assign entry_index = index_q;
	assign stored      = stored_q;
	assign last        = last_q;

endmodule

/* rtl/rmpp_checker.sv */
// Port-level checker for the minute pulse pattern block, with its bind.
`timescale 1ns / 1ps
`include "roman_minute_pulse_pattern_defines.svh"
module rmpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] duration_ms,
	input logic        is_pulse,
	input logic [4:0]  entry_index,
	input logic        last
);
	// a stalled output transaction holds its payload
	`RMPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duration_ms) && $stable(entry_index) && $stable(last))
	// pulses sit on even indexes, gaps on odd ones
	`RMPP_ASSERT_NOW(a_parity, out_valid, is_pulse == !entry_index[0])
	// a pattern always ends on a pulse
	`RMPP_ASSERT_NOW(a_last_pulse, out_valid && last, is_pulse)
	// no pattern is longer than 25 entries
	`RMPP_ASSERT_NOW(a_index_range, out_valid, entry_index <= 5'd24)
endmodule

bind roman_minute_pulse_pattern rmpp_checker u_rmpp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.duration_ms (duration_ms),
	.is_pulse    (is_pulse),
	.entry_index (entry_index),
	.last        (last)
);

/* tb/roman_minute_pulse_pattern_tb.sv */
// Self-checking testbench for the Roman-numeral minute pulse pattern generator.
`timescale 1ns / 1ps
module roman_minute_pulse_pattern_tb;
	import rmpp_pkg::*;

	// Only indexes 0..5 are mapped. These two must be ignored by the block.
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	localparam longint TIMEOUT_NS = 64'd16_000_000;

	// Cycles to let a minute that makes no entries clear the pipe before a register write.
	localparam int SETTLE_CYCLES = 8;

	// One pattern entry as seen on the output channel
	typedef struct packed {
		logic [DUR_W-1:0] duration_ms;
		logic             is_pulse;
		logic [IDX_W-1:0] entry_index;
		logic             stored;
		logic             last;
	} pattern_entry_t;

	// Shadow of the registers, and the entries still owed by the block
	class minute_pattern_board;
		logic [MINUTE_W-1:0] max_minute;
		logic [CAP_W-1:0]    capacity;
		logic [DUR_W-1:0]    short_ms;
		logic [DUR_W-1:0]    medium_ms;
		logic [DUR_W-1:0]    long_ms;
		logic [DUR_W-1:0]    gap_ms;
		pattern_entry_t      owed_entries[$];
		int                  errors;

		function new();
			max_minute = RST_MAX_MINUTE;
			capacity   = RST_CAPACITY;
			short_ms   = RST_SHORT_MS;
			medium_ms  = RST_MEDIUM_MS;
			long_ms    = RST_LONG_MS;
			gap_ms     = RST_GAP_MS;
			errors     = 0;
		endfunction

		// Each register keeps only its low bits; unmapped indexes drop the write.
		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_MAX_MINUTE: max_minute = value[MINUTE_W-1:0];
				REG_CAPACITY:   capacity   = value[CAP_W-1:0];
				REG_SHORT_MS:   short_ms   = value[DUR_W-1:0];
				REG_MEDIUM_MS:  medium_ms  = value[DUR_W-1:0];
				REG_LONG_MS:    long_ms    = value[DUR_W-1:0];
				REG_GAP_MS:     gap_ms     = value[DUR_W-1:0];
				default: ;
			endcase
		endfunction

		// Spell an accepted minute as pulses, then interleave gaps.
		function void note_minute(logic [MINUTE_W-1:0] m);
			logic [MINUTE_W-1:0] lim;
			logic [DUR_W-1:0]    pulses[$];
			int                  tens;
			int                  ones;
			int                  n;
			int                  k;
			pattern_entry_t      e;
			lim = (max_minute > HARD_MINUTE_LIMIT) ? HARD_MINUTE_LIMIT : max_minute;
			if (m == 0 || m > lim)
				return;
			tens = m / 10;
			ones = m % 10;
			repeat (tens) pulses.push_back(long_ms);
			if (ones == 4) begin
				pulses.push_back(short_ms);
				pulses.push_back(medium_ms);
			end else if (ones == 9) begin
				pulses.push_back(short_ms);
				pulses.push_back(long_ms);
			end else if (ones != 0) begin
				n = ones;
				if (ones >= 5) begin
					pulses.push_back(medium_ms);
					n = ones - 5;
				end
				repeat (n) pulses.push_back(short_ms);
			end
			// at most 13 pulses for minute <= 99, so never past 25 entries
			n = 2 * pulses.size() - 1;
			for (k = 0; k < n; k++) begin
				e.is_pulse    = (k % 2 == 0);
				e.duration_ms = e.is_pulse ? pulses[k / 2] : gap_ms;
				e.entry_index = IDX_W'(k);
				e.stored      = (k < capacity);
				e.last        = (k == n - 1);
				owed_entries.push_back(e);
			end
		endfunction

		function void complain(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void check_entry(pattern_entry_t got);
			pattern_entry_t want;
			if (owed_entries.size() == 0) begin
				complain($sformatf("%0t: unexpected entry dur %0d pulse %0b idx %0d stored %0b last %0b",
					$time, got.duration_ms, got.is_pulse, got.entry_index, got.stored, got.last));
				return;
			end
			want = owed_entries.pop_front();
			if (got.duration_ms !== want.duration_ms || got.is_pulse !== want.is_pulse ||
				got.entry_index !== want.entry_index || got.stored !== want.stored ||
				got.last !== want.last)
				complain($sformatf({"%0t: entry mismatch (exp/act) dur %0d/%0d pulse %0b/%0b",
					" idx %0d/%0d stored %0b/%0b last %0b/%0b"}, $time,
					want.duration_ms, got.duration_ms, want.is_pulse, got.is_pulse,
					want.entry_index, got.entry_index, want.stored, got.stored,
					want.last, got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [6:0]  minute;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] duration_ms;
	logic        is_pulse;
	logic [4:0]  entry_index;
	logic        stored;
	logic        last;

	minute_pattern_board sb;
	pattern_entry_t      observed;

	// idle odds in percent per cycle, set per phase by the main sequence
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// long receiver hold-off, handed to the receiver process in cycles
	int hold_request   = 0;

	roman_minute_pulse_pattern dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.minute     (minute),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duration_ms(duration_ms),
		.is_pulse   (is_pulse),
		.entry_index(entry_index),
		.stored     (stored),
		.last       (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("roman_minute_pulse_pattern_tb: done, errors");
		$finish;
	end

	// Receiver: random stalls per phase, plus an occasional long hold-off that
	// lets the minute queue fill so the input side has to back up.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Output monitor: every transaction on the pattern channel is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			observed = '{duration_ms, is_pulse, entry_index, stored, last};
			sb.check_entry(observed);
		end
	end

	// All driving tasks start and end just after a falling edge, with nothing
	// yet scheduled in that step, so no signal gets two updates at once.

	// Offer one minute; valid stays high afterwards unless the next call idles.
	task automatic send_minute(logic [6:0] m);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		minute   <= m;
		do @(posedge clk); while (!in_ready);
		sb.note_minute(m);
		@(negedge clk);
	endtask

	// Drop valid, let every owed entry come out, then allow the pipe to clear.
	task automatic wait_for_patterns();
		in_valid <= 1'b0;
		while (sb.owed_entries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; only called while idle.
	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly minutes that make a pattern, some zeros, some anywhere in range.
	function automatic logic [6:0] pick_minute(logic [6:0] max_min);
		logic [6:0] lim;
		int         r;
		lim = (max_min > HARD_MINUTE_LIMIT) ? HARD_MINUTE_LIMIT : max_min;
		r   = $urandom_range(99);
		if (lim != 0 && r < 82)
			return 7'($urandom_range(lim, 1));
		if (r < 90)
			return 7'd0;
		return 7'($urandom_range(127));
	endfunction

	initial begin
		int p;
		int i;
		int n_items;

		sb       = new();
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		minute   = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed at reset settings: zero, every ones digit, IV and IX after tens,
		// the limit itself, one past it and the top of the field.
		for (i = 0; i < 10; i++)
			send_minute(7'(i));
		// sender holds until the block has emptied
		wait_for_patterns();
		send_minute(7'd10);
		send_minute(7'd14);
		send_minute(7'd19);
		send_minute(7'd40);
		send_minute(7'd44);
		send_minute(7'd49);
		send_minute(7'd55);
		send_minute(7'd58);
		send_minute(7'd59);
		send_minute(7'd60);
		send_minute(7'd127);

		for (p = 0; p < 7; p++) begin
			wait_for_patterns();
			case (p)
				0: begin
					// small buffer; unmapped addresses must not disturb anything
					apb_write(REG_CAPACITY, 32'd5);
					apb_write(REG_SPARE_A, $urandom);
					apb_write(REG_SPARE_B, $urandom);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					// limit written past 99 saturates; nothing stored at all
					apb_write(REG_MAX_MINUTE, 32'd127);
					apb_write(REG_CAPACITY, 32'd0);
					apb_write(REG_SHORT_MS, 32'd0);
					apb_write(REG_MEDIUM_MS, 32'h0000_FFFF);
					apb_write(REG_LONG_MS, 32'h0000_FFFF);
					apb_write(REG_GAP_MS, 32'd0);
					send_idle_pct  = 83;
					recv_stall_pct = 0;
				end
				2: begin
					// capacity above 32 is taken as written
					apb_write(REG_MAX_MINUTE, 32'd99);
					apb_write(REG_CAPACITY, 32'd63);
					apb_write(REG_SHORT_MS, 32'h0000_FFFF);
					apb_write(REG_MEDIUM_MS, 32'd0);
					apb_write(REG_LONG_MS, 32'd0);
					apb_write(REG_GAP_MS, 32'h0000_FFFF);
					send_idle_pct  = 0;
					recv_stall_pct = 83;
				end
				3: begin
					// limit zero: every minute is swallowed
					apb_write(REG_MAX_MINUTE, 32'd0);
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
				4: begin
					apb_write(REG_MAX_MINUTE, 32'd9);
					apb_write(REG_CAPACITY, 32'd1);
					apb_write(REG_SHORT_MS, $urandom_range(16'hFFFF));
					apb_write(REG_MEDIUM_MS, $urandom_range(16'hFFFF));
					apb_write(REG_LONG_MS, $urandom_range(16'hFFFF));
					apb_write(REG_GAP_MS, $urandom_range(16'hFFFF));
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				5: begin
					// full 32-bit garbage; only the low bits of each register count
					apb_write(REG_MAX_MINUTE, $urandom);
					apb_write(REG_CAPACITY, $urandom);
					apb_write(REG_SHORT_MS, $urandom);
					apb_write(REG_MEDIUM_MS, $urandom);
					apb_write(REG_LONG_MS, $urandom);
					apb_write(REG_GAP_MS, $urandom);
					send_idle_pct  = 0;
					recv_stall_pct = 83;
				end
				default: begin
					apb_write(REG_MAX_MINUTE, 32'd98);
					apb_write(REG_CAPACITY, 32'd24);
					apb_write(REG_SHORT_MS, $urandom_range(16'hFFFF));
					apb_write(REG_MEDIUM_MS, $urandom_range(16'hFFFF));
					apb_write(REG_LONG_MS, $urandom_range(16'hFFFF));
					apb_write(REG_GAP_MS, $urandom_range(16'hFFFF));
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase

			// receiver goes quiet while the sender keeps pushing
			if (p == 0 || p == 4)
				hold_request = 300;

			// longest patterns, and just past the saturated limit
			if (p == 1) begin
				send_minute(7'd99);
				send_minute(7'd98);
				send_minute(7'd88);
				send_minute(7'd97);
				send_minute(7'd100);
			end

			n_items = (p == 3) ? 12 : 72;
			repeat (n_items) send_minute(pick_minute(sb.max_minute));
		end

		wait_for_patterns();
		if (sb.errors == 0)
			$display("roman_minute_pulse_pattern_tb: done, clean");
		else
			$display("roman_minute_pulse_pattern_tb: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/rmpp_pkg.sv
rtl/rmpp_front.sv
rtl/rmpp_queue.sv
rtl/rmpp_back.sv
rtl/roman_minute_pulse_pattern.sv
rtl/rmpp_checker.sv
tb/roman_minute_pulse_pattern_tb.sv
